// ----- hdl/m3i_pkg.sv -----
`default_nettype none
package m3i_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

// ----- hdl/m3i_front.sv -----
`default_nettype none
module m3i_front #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire logic [8:0][DW-1:0]          i_m,
    input  wire logic [DW-2:0]               i_limit,
    output logic                             o_vld,
    output logic [8:0][2*DW-1:0]             o_abs_cof,
    output logic [8:0]                       o_neg,
    output logic [3*DW+2:0]                  o_absd,
    output logic                             o_sing
);

    localparam int CFW  = 2 * DW + 1;
    localparam int PW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int THW  = DW + 2 * FB;

    logic [6:0]                 r_vld;
    logic signed [DW-1:0]       r_a     [0:8];
    logic signed [2*DW-1:0]     r_pp    [0:8];
    logic signed [2*DW-1:0]     r_pq    [0:8];
    logic signed [DW-1:0]       r_row1  [0:2];
    logic signed [DW-1:0]       r_row2  [0:2];
    logic signed [CFW-1:0]      r_cof2  [0:8];
    logic signed [CFW-1:0]      r_cof3  [0:8];
    logic signed [CFW-1:0]      r_cof4  [0:8];
    logic signed [CFW-1:0]      r_cof5  [0:8];
    logic signed [PW-1:0]       r_plo   [0:2];
    logic signed [PW-1:0]       r_phi   [0:2];
    logic signed [DETW-1:0]     r_t     [0:2];
    logic signed [DETW-1:0]     r_det;
    logic [8:0][2*DW-1:0]       r_abs_cof;
    logic [8:0]                 r_neg;
    logic [DETW-1:0]            r_absd;
    logic                       r_sing;
    logic [DETW-1:0]            w_absd;
    logic [THW-1:0]             w_thr;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_a[k] <= $signed(i_m[k]);
        end
    end

    // 2x2 products of the adjugate
    for (genvar k = 0; k < 9; k++) begin : g_cof
        localparam int R  = k / 3;
        localparam int C  = k % 3;
        localparam int C1 = (C + 1) % 3;
        localparam int C2 = (C + 2) % 3;
        localparam int R1 = (R + 1) % 3;
        localparam int R2 = (R + 2) % 3;
        always_ff @(posedge i_clk) begin
            r_pp[k]   <= r_a[C1*3+R1] * r_a[C2*3+R2];
            r_pq[k]   <= r_a[C1*3+R2] * r_a[C2*3+R1];
            r_cof2[k] <= $signed({r_pp[k][2*DW-1], r_pp[k]})
                       - $signed({r_pq[k][2*DW-1], r_pq[k]});
        end
    end

    // determinant along row 0, cofactor split in low and high halves
    for (genvar k = 0; k < 3; k++) begin : g_det
        always_ff @(posedge i_clk) begin
            r_row1[k] <= r_a[k];
            r_row2[k] <= r_row1[k];
            r_plo[k]  <= r_row2[k] * $signed({1'b0, r_cof2[k*3][DW-1:0]});
            r_phi[k]  <= r_row2[k] * $signed(r_cof2[k*3][CFW-1:DW]);
            r_t[k]    <= ($signed({{(DETW-PW){r_phi[k][PW-1]}}, r_phi[k]}) <<< DW)
                       + $signed({{(DETW-PW){r_plo[k][PW-1]}}, r_plo[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_cof3 <= r_cof2;
        r_cof4 <= r_cof3;
        r_cof5 <= r_cof4;
        r_det  <= r_t[0] + r_t[1] + r_t[2];
    end

    // classify
    always_comb begin
        w_absd = r_det[DETW-1] ? DETW'(-r_det) : DETW'(r_det);
        w_thr  = THW'({1'b0, i_limit} + 1'b1) << (2 * FB);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_abs_cof[k] <= r_cof5[k][CFW-1] ? (2*DW)'(-r_cof5[k]) : (2*DW)'(r_cof5[k]);
            r_neg[k]     <= r_cof5[k][CFW-1] ^ r_det[DETW-1];
        end
        r_absd <= w_absd;
        r_sing <= w_absd < {{(DETW-THW){1'b0}}, w_thr};
    end

    assign o_vld     = r_vld[6];
    assign o_abs_cof = r_abs_cof;
    assign o_neg     = r_neg;
    assign o_absd    = r_absd;
    assign o_sing    = r_sing;

endmodule
`default_nettype wire

// ----- hdl/m3i_queue.sv -----
`default_nettype none
module m3i_queue
    import m3i_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output t_q_status             o_status
);

    logic [WIDTH-1:0]    r_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_CW-1:0] r_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_status.full  = r_cnt == QUEUE_CW'(QUEUE_DEPTH);
    assign o_status.empty = r_cnt == '0;
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QUEUE_CW'(w_push) - QUEUE_CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data = r_mem[r_rp];

endmodule
`default_nettype wire

// ----- hdl/m3i_back.sv -----
`default_nettype none
module m3i_back #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    input  wire logic [8:0][2*DW-1:0] i_abs_cof,
    input  wire logic [8:0]           i_neg,
    input  wire logic [3*DW+2:0]      i_absd,
    input  wire logic                 i_sing,
    output logic                      o_vld,
    output logic [8:0][DW-1:0]        o_inv,
    output logic                      o_sing
);

    localparam int NW   = 2 * DW + 2 * FB;
    localparam int DETW = 3 * DW + 3;
    localparam int CW   = DETW + DW;
    localparam int ST   = DW;

    logic [ST:0]                r_vld;
    logic [8:0][NW-1:0]         r_rem  [0:ST];
    logic [8:0][DW-1:0]         r_quo  [0:ST];
    logic [DETW-1:0]            r_den  [0:ST];
    logic [8:0]                 r_neg  [0:ST];
    logic                       r_sing [0:ST];
    logic                       r_out_vld;
    logic [8:0][DW-1:0]         r_inv;
    logic                       r_out_sing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[ST-1:0], i_vld};
            r_out_vld <= r_vld[ST];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 9; l++) begin
            r_rem[0][l] <= {i_abs_cof[l], {(2*FB){1'b0}}};
            r_quo[0][l] <= '0;
        end
        r_den[0]  <= i_absd;
        r_neg[0]  <= i_neg;
        r_sing[0] <= i_sing;
    end

    // one quotient bit per stage, top bit flags saturation
    for (genvar s = 0; s < ST; s++) begin : g_stage
        localparam int J = ST - 1 - s;
        logic [CW-1:0]      w_dsh;
        logic [8:0]         w_ge;
        logic [8:0][NW-1:0] w_sub;

        always_comb begin
            w_dsh = {{(CW-DETW){1'b0}}, r_den[s]} << J;
            for (int l = 0; l < 9; l++) begin
                w_ge[l]  = {{(CW-NW){1'b0}}, r_rem[s][l]} >= w_dsh;
                w_sub[l] = NW'({{(CW-NW){1'b0}}, r_rem[s][l]} - w_dsh);
            end
        end

        always_ff @(posedge i_clk) begin
            for (int l = 0; l < 9; l++) begin
                r_rem[s+1][l] <= w_ge[l] ? w_sub[l] : r_rem[s][l];
                r_quo[s+1][l] <= r_quo[s][l] | ({{(DW-1){1'b0}}, w_ge[l]} << J);
            end
            r_den[s+1]  <= r_den[s];
            r_neg[s+1]  <= r_neg[s];
            r_sing[s+1] <= r_sing[s];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 9; l++) begin
            if (r_sing[ST]) begin
                r_inv[l] <= '0;
            end else if (r_quo[ST][l][DW-1]) begin
                r_inv[l] <= r_neg[ST][l] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            end else begin
                r_inv[l] <= r_neg[ST][l] ? DW'(-r_quo[ST][l]) : r_quo[ST][l];
            end
        end
        r_out_sing <= r_sing[ST];
    end

    assign o_vld  = r_out_vld;
    assign o_inv  = r_inv;
    assign o_sing = r_out_sing;

endmodule
`default_nettype wire

// ----- hdl/matrix3x3_inverse_core.sv -----
// 3x3 matrix inverse by adjugate, one matrix accepted per clock. busy stays low in normal
// use because the result side never stalls; a request is accepted whenever start is high.
// Each result appears for exactly one cycle with o_done high. A request passes first
// through the front stages for cofactors, determinant and singular check, then the queue,
// then the divider pipeline, which resolves one quotient bit per stage for all nine
// elements. o_singular marks a determinant magnitude at or below the limit register, and
// then all nine elements are zero. The user must write the limit only while no request
// is in flight; the block itself does not enforce this.
`default_nettype none
module matrix3x3_inverse_core
    import m3i_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [DATA_WIDTH-1:0] i_m00,
    input  wire logic [DATA_WIDTH-1:0] i_m01,
    input  wire logic [DATA_WIDTH-1:0] i_m02,
    input  wire logic [DATA_WIDTH-1:0] i_m10,
    input  wire logic [DATA_WIDTH-1:0] i_m11,
    input  wire logic [DATA_WIDTH-1:0] i_m12,
    input  wire logic [DATA_WIDTH-1:0] i_m20,
    input  wire logic [DATA_WIDTH-1:0] i_m21,
    input  wire logic [DATA_WIDTH-1:0] i_m22,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [DATA_WIDTH-2:0] i_cfg_data,
    output logic                       o_done,
    output logic [DATA_WIDTH-1:0]      o_inv00,
    output logic [DATA_WIDTH-1:0]      o_inv01,
    output logic [DATA_WIDTH-1:0]      o_inv02,
    output logic [DATA_WIDTH-1:0]      o_inv10,
    output logic [DATA_WIDTH-1:0]      o_inv11,
    output logic [DATA_WIDTH-1:0]      o_inv12,
    output logic [DATA_WIDTH-1:0]      o_inv20,
    output logic [DATA_WIDTH-1:0]      o_inv21,
    output logic [DATA_WIDTH-1:0]      o_inv22,
    output logic                       o_singular
);

    localparam int DW   = DATA_WIDTH;
    localparam int DETW = 3 * DW + 3;
    localparam int QW   = 9 * 2 * DW + 9 + DETW + 1;

    logic [DW-2:0]              r_limit;
    logic                       w_accept;
    logic [8:0][DW-1:0]         w_m;
    logic                       w_f_vld;
    logic [8:0][2*DW-1:0]       w_f_cof;
    logic [8:0]                 w_f_neg;
    logic [DETW-1:0]            w_f_absd;
    logic                       w_f_sing;
    logic [QW-1:0]              w_q_out;
    t_q_status                  w_q_status;
    logic [8:0][2*DW-1:0]       w_b_cof;
    logic [8:0]                 w_b_neg;
    logic [DETW-1:0]            w_b_absd;
    logic                       w_b_sing;
    logic [8:0][DW-1:0]         w_inv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    assign busy     = w_q_status.full;
    assign w_accept = start && !busy;
    assign w_m      = {i_m22, i_m21, i_m20, i_m12, i_m11, i_m10, i_m02, i_m01, i_m00};

    m3i_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_accept),
        .i_m       (w_m),
        .i_limit   (r_limit),
        .o_vld     (w_f_vld),
        .o_abs_cof (w_f_cof),
        .o_neg     (w_f_neg),
        .o_absd    (w_f_absd),
        .o_sing    (w_f_sing)
    );

    m3i_queue #(.WIDTH(QW)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_f_vld),
        .i_data   ({w_f_cof, w_f_neg, w_f_absd, w_f_sing}),
        .i_pop    (1'b1),
        .o_data   (w_q_out),
        .o_status (w_q_status)
    );

    assign {w_b_cof, w_b_neg, w_b_absd, w_b_sing} = w_q_out;

    m3i_back #(.DW(DW), .FB(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (!w_q_status.empty),
        .i_abs_cof (w_b_cof),
        .i_neg     (w_b_neg),
        .i_absd    (w_b_absd),
        .i_sing    (w_b_sing),
        .o_vld     (o_done),
        .o_inv     (w_inv),
        .o_sing    (o_singular)
    );

    assign o_inv00 = w_inv[0];
    assign o_inv01 = w_inv[1];
    assign o_inv02 = w_inv[2];
    assign o_inv10 = w_inv[3];
    assign o_inv11 = w_inv[4];
    assign o_inv12 = w_inv[5];
    assign o_inv20 = w_inv[6];
    assign o_inv21 = w_inv[7];
    assign o_inv22 = w_inv[8];

    a_no_backlog : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("request queue filled up");

    a_queue_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue full and empty at once");

    a_singular_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_singular) |-> (w_inv == '0))
        else $error("singular result with nonzero elements");

    a_front_to_queue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_f_vld |=> !w_q_status.empty)
        else $error("front result lost before queue");

endmodule
`default_nettype wire

// ----- tb/matrix3x3_inverse_core_test.sv -----
`default_nettype none
module matrix3x3_inverse_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW      = 32;
    localparam int LATENCY = DW + 10;
    localparam logic [DW-1:0] ONE  = 32'h0001_0000;
    localparam logic [DW-1:0] MAXV = 32'h7fff_ffff;
    localparam logic [DW-1:0] MINV = 32'h8000_0000;
    localparam logic [DW-2:0] LIMIT_MAX = '1;

    typedef logic [8:0][DW-1:0] mat_t;
    typedef struct packed {
        mat_t inv;
        logic sing;
    } inverse_t;
    typedef struct packed {
        mat_t     m;
        bit       typed;
        inverse_t res;
    } vector_t;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    mat_t          mat_in;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [DW-2:0] i_cfg_data;
    logic          o_done;
    mat_t          inv_out;
    logic          o_singular;

    logic [DW-2:0] limit_now;
    inverse_t      inverse_queue[$];
    int            errors;

    matrix3x3_inverse_core #(.DATA_WIDTH(DW), .FRAC_BITS(16)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_m00      (mat_in[0]),
        .i_m01      (mat_in[1]),
        .i_m02      (mat_in[2]),
        .i_m10      (mat_in[3]),
        .i_m11      (mat_in[4]),
        .i_m12      (mat_in[5]),
        .i_m20      (mat_in[6]),
        .i_m21      (mat_in[7]),
        .i_m22      (mat_in[8]),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_inv00    (inv_out[0]),
        .o_inv01    (inv_out[1]),
        .o_inv02    (inv_out[2]),
        .o_inv10    (inv_out[3]),
        .o_inv11    (inv_out[4]),
        .o_inv12    (inv_out[5]),
        .o_inv20    (inv_out[6]),
        .o_inv21    (inv_out[7]),
        .o_inv22    (inv_out[8]),
        .o_singular (o_singular)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // exact adjugate inverse with truncating division and saturation
    function automatic inverse_t compute_inverse(mat_t m, logic [DW-2:0] lim);
        logic signed [159:0] a[3][3];
        logic signed [159:0] cof[3][3];
        logic signed [159:0] det;
        logic signed [159:0] num;
        logic [159:0]        abs_det;
        logic [159:0]        abs_num;
        logic [159:0]        thr;
        logic [159:0]        quo;
        logic [159:0]        top;
        inverse_t            res;
        bit                  neg;
        for (int k = 0; k < 9; k++) a[k/3][k%3] = $signed(m[k]);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                cof[r][c] = a[(c+1)%3][(r+1)%3] * a[(c+2)%3][(r+2)%3]
                          - a[(c+1)%3][(r+2)%3] * a[(c+2)%3][(r+1)%3];
            end
        end
        det = 0;
        for (int k = 0; k < 3; k++) det = det + a[0][k] * cof[k][0];
        abs_det = (det < 0) ? -det : det;
        thr = ({129'd0, lim} + 160'd1) << 32;
        res = '0;
        if (abs_det < thr) begin
            res.sing = 1'b1;
            return res;
        end
        for (int k = 0; k < 9; k++) begin
            num     = cof[k/3][k%3] <<< 32;
            neg     = (num < 0) != (det < 0);
            abs_num = (num < 0) ? -num : num;
            quo     = abs_num / abs_det;
            top     = neg ? 160'h8000_0000 : 160'h7fff_ffff;
            if (quo > top) quo = top;
            res.inv[k] = neg ? -quo[DW-1:0] : quo[DW-1:0];
        end
        return res;
    endfunction

    function automatic logic [DW-1:0] small_q();
        return DW'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endfunction

    function automatic mat_t random_matrix();
        mat_t m;
        logic [DW-1:0] big;
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++) m[k] = small_q();
        case (kind)
            4, 5: begin
                for (int k = 0; k < 9; k++) m[k] = $urandom;
            end
            6: begin
                // triangular with huge off-diagonal terms, drives saturation
                big = DW'($urandom_range(1, 32'h7fff_ffff));
                m[0] = ONE; m[4] = ONE; m[8] = ONE;
                m[3] = 0; m[6] = 0; m[7] = 0;
                m[1] = $urandom_range(0, 1) ? big : -big;
                m[2] = $urandom;
                m[5] = $urandom_range(0, 1) ? big : -big;
            end
            7: begin
                for (int k = 0; k < 3; k++) m[6+k] = m[k] + m[3+k];
            end
            8: begin
                for (int k = 0; k < 9; k++) m[k] = 0;
                for (int k = 0; k < 3; k++) m[4*k] = $urandom >> $urandom_range(0, 31);
            end
            9: begin
                for (int k = 0; k < 9; k++) m[k] = $signed($urandom) >>> $urandom_range(0, 31);
            end
            default: ;
        endcase
        return m;
    endfunction

    task automatic write_limit(logic [DW-2:0] value);
        start <= 1'b0;
        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        limit_now = value;
    endtask

    task automatic send_request(mat_t m, int idle_pct);
        start  <= 1'b1;
        mat_in <= m;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        inverse_queue.push_back(compute_inverse(m, limit_now));
        if ($urandom_range(1, 100) <= idle_pct) begin
            start  <= 1'b0;
            mat_in <= {9{$urandom}};
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_vector(vector_t v);
        inverse_t want;
        send_request(v.m, 0);
        if (v.typed) begin
            want = compute_inverse(v.m, limit_now);
            if (want != v.res) begin
                $display("%0t table row mismatch: table %h computed %h", $time, v.res, want);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        inverse_t want;
        if (i_rst_n && o_done) begin
            if (inverse_queue.size() == 0) begin
                $display("%0t unexpected result: inv %h singular %b", $time, inv_out,
                         o_singular);
                errors++;
            end else begin
                want = inverse_queue.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (inv_out[k] !== want.inv[k]) begin
                        $display("%0t inv%0d%0d expected %h got %h", $time, k/3, k%3,
                                 want.inv[k], inv_out[k]);
                        errors++;
                    end
                end
                if (o_singular !== want.sing) begin
                    $display("%0t singular expected %b got %b", $time, want.sing,
                             o_singular);
                    errors++;
                end
            end
        end
    end

    initial begin
        vector_t       table_rows[$];
        inverse_t      r;
        mat_t          m;
        logic [DW-2:0] limits[5];
        int            idle_pcts[5];
        errors      = 0;
        limit_now   = '0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        mat_in      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity
        m = '0; m[0] = ONE; m[4] = ONE; m[8] = ONE;
        r = '0; r.inv = m;
        table_rows.push_back('{m, 1'b1, r});
        // negated identity
        m = '0; m[0] = -ONE; m[4] = -ONE; m[8] = -ONE;
        r = '0; r.inv = m;
        table_rows.push_back('{m, 1'b1, r});
        // diag 2 gives diag 0.5
        m = '0; m[0] = 2*ONE; m[4] = 2*ONE; m[8] = 2*ONE;
        r = '0; r.inv[0] = 32'h8000; r.inv[4] = 32'h8000; r.inv[8] = 32'h8000;
        table_rows.push_back('{m, 1'b1, r});
        // zero, all max, all min: determinant zero
        r = '0; r.sing = 1'b1;
        table_rows.push_back('{'0, 1'b1, r});
        m = '0; for (int k = 0; k < 9; k++) m[k] = MAXV;
        table_rows.push_back('{m, 1'b1, r});
        m = '0; for (int k = 0; k < 9; k++) m[k] = MINV;
        table_rows.push_back('{m, 1'b1, r});
        // tiny determinant below the limit
        m = '0; m[0] = 1; m[4] = 1; m[8] = 1;
        table_rows.push_back('{m, 1'b1, r});
        // saturation both ways
        m = '0; m[0] = ONE; m[4] = ONE; m[8] = ONE; m[1] = MAXV; m[5] = MAXV; m[2] = MINV;
        table_rows.push_back('{m, 1'b0, '0});
        m[1] = MINV; m[5] = MAXV; m[2] = MAXV;
        table_rows.push_back('{m, 1'b0, '0});
        // extreme diagonal and mixed extremes
        m = '0; m[0] = MAXV; m[4] = MINV; m[8] = MAXV;
        table_rows.push_back('{m, 1'b0, '0});
        m = '0; m[0] = MINV; m[1] = MAXV; m[4] = MINV; m[5] = MAXV; m[8] = MINV; m[3] = 1;
        table_rows.push_back('{m, 1'b0, '0});
        m = '0; m[2] = ONE; m[4] = ONE; m[6] = ONE;
        table_rows.push_back('{m, 1'b0, '0});
        m = '0; m[0] = 32'h0000_0800; m[4] = 32'h0000_0800; m[8] = 32'h0000_0800;
        table_rows.push_back('{m, 1'b0, '0});
        m = '0; m[0] = 32'h5555_5555; m[1] = 32'haaaa_aaaa; m[3] = 32'hffff_ffff;
        m[4] = 32'h0f0f_0f0f; m[8] = 32'hf0f0_f0f0; m[6] = 32'h1234_5678;
        table_rows.push_back('{m, 1'b0, '0});

        foreach (table_rows[i]) send_vector(table_rows[i]);

        limits    = '{31'd0, 31'd1, LIMIT_MAX, 31'd0, 31'd0};
        limits[3] = (DW-1)'($urandom_range(0, 64));
        limits[4] = (DW-1)'($urandom);
        idle_pcts = '{0, 63, 26, 63, 0};
        for (int p = 0; p < 5; p++) begin
            write_limit(limits[p]);
            for (int n = 0; n < 287; n++) send_request(random_matrix(), idle_pcts[p]);
        end
        start <= 1'b0;
        write_limit('0);
        for (int n = 0; n < 20; n++) send_request(random_matrix(), 0);
        start <= 1'b0;

        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
